// ===== design/obstacle_avoid_drive_controller_assert.svh =====
// Assertion macros for the drive controller.
// Each check is clocked on clk_i and disabled while rst_ni is low.
`ifndef OBSTACLE_AVOID_DRIVE_CONTROLLER_ASSERT_SVH
`define OBSTACLE_AVOID_DRIVE_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

`define OADC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("oadc assertion failed");

`define OADC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("oadc assertion failed");

`else

`define OADC_ASSERT(lbl, prop)

`define OADC_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== design/oadc_pkg.sv =====
package oadc_pkg;

  // divider geometry: dividend fits 19 bits, quotient always below 512
  localparam int unsigned DIVIDEND_W = 19;
  localparam int unsigned QUOT_W     = 9;
  localparam int unsigned RAW_W      = 10;

  localparam logic [1:0] CH_FRONT = 2'd0;
  localparam logic [1:0] CH_RIGHT = 2'd1;
  localparam logic [1:0] CH_LEFT  = 2'd2;

  localparam logic [2:0] REG_FRONT_GAP   = 3'd0;
  localparam logic [2:0] REG_SIDE_GAP    = 3'd1;
  localparam logic [2:0] REG_TURN_RESET  = 3'd2;
  localparam logic [2:0] REG_TURN_LIMIT  = 3'd3;
  localparam logic [2:0] REG_CRUISE_DUTY = 3'd4;
  localparam logic [2:0] REG_TURN_SPEED  = 3'd5;

  localparam logic [3:0] PINS_STOP  = 4'd0;
  localparam logic [3:0] PINS_FWD   = 4'd9;
  localparam logic [3:0] PINS_LEFT  = 4'd10;
  localparam logic [3:0] PINS_RIGHT = 4'd5;

  localparam logic [7:0] FRONT_DIST_RESET = 8'd70;
  localparam logic [6:0] SIDE_DIST_RESET  = 7'd35;

  typedef enum logic [1:0] {
    RUN_STOP = 2'd0,
    RUN_FWD  = 2'd1,
    RUN_TURN = 2'd2
  } run_mode_e;

  typedef enum logic [1:0] {
    DRV_STOP  = 2'd0,
    DRV_FWD   = 2'd1,
    DRV_LEFT  = 2'd2,
    DRV_RIGHT = 2'd3
  } drive_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_WAIT,
    SEQ_UPD
  } seq_e;

  typedef struct packed {
    logic [9:0] raw_front;
    logic [9:0] raw_right;
    logic [9:0] raw_left;
    logic       start_pressed;
    logic       stop_pressed;
  } in_word_t;

  typedef struct packed {
    logic [1:0] drive_mode;
    logic [3:0] pin_pattern;
    logic [7:0] pwm_duty;
    logic [1:0] run_mode;
    logic [7:0] dist_front;
    logic [6:0] dist_right;
    logic [6:0] dist_left;
    logic [2:0] right_turns;
    logic [2:0] left_turns;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic [7:0]  front_gap;
    logic [7:0]  side_gap;
    logic [15:0] turn_reset_ticks;
    logic [2:0]  turn_limit;
    logic [7:0]  cruise_duty;
    logic [7:0]  turn_speed;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    front_gap:        8'd50,
    side_gap:         8'd25,
    turn_reset_ticks: 16'd110,
    turn_limit:       3'd4,
    cruise_duty:      8'd200,
    turn_speed:       8'd120
  };

  typedef struct packed {
    logic [1:0] drive_mode;
    logic [3:0] pin_pattern;
    logic [7:0] pwm_duty;
    logic [1:0] run_mode;
    logic [2:0] right_turns;
    logic [2:0] left_turns;
  } drive_res_t;

  function automatic logic [DIVIDEND_W-1:0] lin_ms(input logic [1:0] ch);
    logic [DIVIDEND_W-1:0] ms;
    case (ch)
      CH_FRONT: ms = 19'd302077;
      CH_RIGHT: ms = 19'd362057;
      default:  ms = 19'd280009;
    endcase
    return ms;
  endfunction

  function automatic logic [9:0] lin_ds(input logic [1:0] ch);
    logic [9:0] ds;
    case (ch)
      CH_FRONT: ds = 10'd723;
      default:  ds = 10'd971;
    endcase
    return ds;
  endfunction

  // quotient minus offset, with both out-of-range codes; bounds are moved
  // onto the quotient so everything stays unsigned
  function automatic logic [7:0] lin_clamp(input logic [1:0] ch,
                                           input logic [QUOT_W-1:0] q);
    logic [QUOT_W-1:0] q_hi;
    logic [QUOT_W-1:0] q_lo;
    logic [QUOT_W-1:0] k;
    logic [7:0]        v_hi;
    logic [7:0]        v_lo;
    logic [7:0]        v;
    case (ch)
      CH_FRONT: begin
        q_hi = 9'd165; q_lo = 9'd35; k = 9'd15; v_hi = 8'd151; v_lo = 8'd19;
      end
      default: begin
        q_hi = 9'd110; q_lo = 9'd40; k = 9'd30; v_hi = 8'd81; v_lo = 8'd9;
      end
    endcase
    if (q > q_hi) begin
      v = v_hi;
    end else if (q < q_lo) begin
      v = v_lo;
    end else begin
      v = 8'(q - k);
    end
    return v;
  endfunction

endpackage

// ===== design/oadc_chan_if.sv =====
interface oadc_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/oadc_div.sv =====
// Restoring divider, one quotient bit per cycle, MSB first.
module oadc_div #(
  parameter int unsigned DW = 15
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [oadc_pkg::DIVIDEND_W-1:0] dividend_i,
  input  logic [DW-1:0]                   divisor_i,
  output logic                            done_o,
  output logic [oadc_pkg::QUOT_W-1:0]     quot_o
);

  localparam int unsigned RW  = oadc_pkg::DIVIDEND_W;
  localparam int unsigned QW  = oadc_pkg::QUOT_W;
  localparam int unsigned CW  = DW + QW - 1;
  localparam int unsigned CNW = $clog2(QW);

  logic [RW-1:0]  rem_q, rem_d;
  logic [CW-1:0]  den_q;
  logic [QW-1:0]  quot_q;
  logic [CNW-1:0] cnt_q;
  logic           busy_q;
  logic           done_q;
  logic [CW-1:0]  rem_ext;
  logic           ge;

  assign rem_ext = CW'(rem_q);
  assign ge      = rem_ext >= den_q;
  assign rem_d   = ge ? RW'(rem_ext - den_q) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNW'(QW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      den_q <= CW'(divisor_i) << (QW - 1);
    end else if (busy_q) begin
      rem_q  <= rem_d;
      den_q  <= den_q >> 1;
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== design/oadc_drive.sv =====
// Drive state machine with anti-loop turn counters, updated once per tick.
module oadc_drive (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               start_i,
  input  logic               stop_i,
  input  logic [7:0]         dist_front_i,
  input  logic [6:0]         dist_right_i,
  input  logic [6:0]         dist_left_i,
  input  oadc_pkg::cfg_t     cfg_i,
  output oadc_pkg::drive_res_t res_o
);

  oadc_pkg::run_mode_e mode_q, mode_d, mode_btn;
  logic        left_q, left_d;
  logic [2:0]  rcnt_q, rcnt_d;
  logic [2:0]  lcnt_q, lcnt_d;
  logic [15:0] ticks_q, ticks_d, ticks_inc;
  logic        obstacle;
  logic        pick_left;

  assign ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;

  // stop wins over start
  always_comb begin
    mode_btn = mode_q;
    if (start_i && mode_q == oadc_pkg::RUN_STOP) begin
      mode_btn = oadc_pkg::RUN_FWD;
    end
    if (stop_i) begin
      mode_btn = oadc_pkg::RUN_STOP;
    end
  end

  assign obstacle = (dist_front_i < cfg_i.front_gap) ||
                    ({1'b0, dist_right_i} < cfg_i.side_gap) ||
                    ({1'b0, dist_left_i} < cfg_i.side_gap);

  // next state
  always_comb begin
    mode_d    = mode_btn;
    left_d    = left_q;
    rcnt_d    = rcnt_q;
    lcnt_d    = lcnt_q;
    ticks_d   = ticks_inc;
    pick_left = dist_right_i > dist_left_i;
    case (mode_btn)
      oadc_pkg::RUN_FWD: begin
        if (ticks_inc >= cfg_i.turn_reset_ticks) begin
          rcnt_d = 3'd0;
          lcnt_d = 3'd0;
        end
        if (obstacle) begin
          if (rcnt_d >= cfg_i.turn_limit) begin
            pick_left = 1'b1;
            rcnt_d    = 3'd0;
          end else if (lcnt_d >= cfg_i.turn_limit) begin
            pick_left = 1'b0;
            lcnt_d    = 3'd0;
          end
          if (pick_left) begin
            lcnt_d = (lcnt_d == 3'd7) ? lcnt_d : lcnt_d + 3'd1;
          end else begin
            rcnt_d = (rcnt_d == 3'd7) ? rcnt_d : rcnt_d + 3'd1;
          end
          left_d  = pick_left;
          ticks_d = 16'd0;
          mode_d  = oadc_pkg::RUN_TURN;
        end
      end
      oadc_pkg::RUN_TURN: begin
        if (!obstacle) begin
          mode_d = oadc_pkg::RUN_FWD;
        end
      end
      default: begin
        mode_d = oadc_pkg::RUN_STOP;
      end
    endcase
  end

  // motor outputs for this tick
  always_comb begin
    case (mode_btn)
      oadc_pkg::RUN_FWD: begin
        res_o.drive_mode  = oadc_pkg::DRV_FWD;
        res_o.pin_pattern = oadc_pkg::PINS_FWD;
        res_o.pwm_duty    = cfg_i.cruise_duty;
      end
      oadc_pkg::RUN_TURN: begin
        res_o.pwm_duty = cfg_i.turn_speed;
        if (left_q) begin
          res_o.drive_mode  = oadc_pkg::DRV_LEFT;
          res_o.pin_pattern = oadc_pkg::PINS_LEFT;
        end else begin
          res_o.drive_mode  = oadc_pkg::DRV_RIGHT;
          res_o.pin_pattern = oadc_pkg::PINS_RIGHT;
        end
      end
      default: begin
        res_o.drive_mode  = oadc_pkg::DRV_STOP;
        res_o.pin_pattern = oadc_pkg::PINS_STOP;
        res_o.pwm_duty    = cfg_i.cruise_duty;
      end
    endcase
    res_o.run_mode    = mode_d;
    res_o.right_turns = rcnt_d;
    res_o.left_turns  = lcnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= oadc_pkg::RUN_STOP;
      left_q  <= 1'b0;
      rcnt_q  <= 3'd0;
      lcnt_q  <= 3'd0;
      ticks_q <= 16'd0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      left_q  <= left_d;
      rcnt_q  <= rcnt_d;
      lcnt_q  <= lcnt_d;
      ticks_q <= ticks_d;
    end
  end

endmodule

// ===== design/obstacle_avoid_drive_controller.sv =====
// Obstacle avoiding drive controller, one word in and one word out per tick.
// in_i carries three IR samples and the two buttons; out_o carries motor
// pins, PWM duty, run mode, filtered distances and turn counters; cfg_i
// writes the six thresholds and speeds (index, value), always ready.
// An input word is taken only while no tick is in progress. The three IR
// channels share one restoring divider that yields one quotient bit per
// cycle; each channel is loaded, divided and written back in turn, front,
// right, then left.
// The result sits in an output register: a new input is taken while it
// waits. If the receiver is still stalling when the next tick finishes,
// that tick holds in its last step until the register frees, and in_i
// stays not ready meanwhile.
// Reset puts the vehicle in stop, distances at 70/35/35 cm, counters at
// zero and the registers at their defaults; there is no clearing pass.
module obstacle_avoid_drive_controller #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  oadc_chan_if.sink        in_i,
  oadc_chan_if.source      out_o,
  oadc_chan_if.sink        cfg_i
);

  `include "obstacle_avoid_drive_controller_assert.svh"

  localparam int unsigned EFF = (ADC_BITS < oadc_pkg::RAW_W) ? ADC_BITS : oadc_pkg::RAW_W;
  localparam int unsigned DW  = EFF + 5;

  oadc_pkg::seq_e state_q, state_d;
  logic [1:0]     ch_q;
  logic [EFF-1:0] raw_f_q, raw_r_q, raw_l_q, raw_sel;
  logic           start_q, stop_q;
  logic [7:0]     dist_f_q;
  logic [6:0]     dist_r_q, dist_l_q;
  oadc_pkg::cfg_t cfg_q;

  logic           in_ready, div_start, res_load;
  logic           div_done;
  logic [oadc_pkg::QUOT_W-1:0] div_quot;
  logic [DW-1:0]  divisor;
  logic [7:0]     lin_val, prev_dist, avg;

  logic                  out_valid_q;
  oadc_pkg::out_word_t   out_data_q;
  oadc_pkg::drive_res_t  drv_res;

  always_comb begin
    case (ch_q)
      oadc_pkg::CH_FRONT: begin
        raw_sel   = raw_f_q;
        prev_dist = dist_f_q;
      end
      oadc_pkg::CH_RIGHT: begin
        raw_sel   = raw_r_q;
        prev_dist = {1'b0, dist_r_q};
      end
      default: begin
        raw_sel   = raw_l_q;
        prev_dist = {1'b0, dist_l_q};
      end
    endcase
  end

  assign divisor = DW'({raw_sel, 4'b0000}) + DW'(oadc_pkg::lin_ds(ch_q));

  oadc_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (oadc_pkg::lin_ms(ch_q)),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign lin_val = oadc_pkg::lin_clamp(ch_q, div_quot);
  assign avg     = 8'((9'(lin_val) + 9'(prev_dist)) >> 1);

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      oadc_pkg::SEQ_IDLE: begin
        if (in_i.valid) begin
          state_d = oadc_pkg::SEQ_LOAD;
        end
      end
      oadc_pkg::SEQ_LOAD: begin
        state_d = oadc_pkg::SEQ_WAIT;
      end
      oadc_pkg::SEQ_WAIT: begin
        if (div_done) begin
          state_d = (ch_q == oadc_pkg::CH_LEFT) ? oadc_pkg::SEQ_UPD : oadc_pkg::SEQ_LOAD;
        end
      end
      oadc_pkg::SEQ_UPD: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = oadc_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = oadc_pkg::SEQ_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    res_load  = 1'b0;
    case (state_q)
      oadc_pkg::SEQ_IDLE: in_ready  = 1'b1;
      oadc_pkg::SEQ_LOAD: div_start = 1'b1;
      oadc_pkg::SEQ_UPD:  res_load  = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oadc_pkg::SEQ_IDLE;
      ch_q    <= oadc_pkg::CH_FRONT;
    end else begin
      state_q <= state_d;
      if (in_ready && in_i.valid) begin
        ch_q <= oadc_pkg::CH_FRONT;
      end else if (state_q == oadc_pkg::SEQ_WAIT && div_done) begin
        ch_q <= ch_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      raw_f_q <= in_i.data.raw_front[EFF-1:0];
      raw_r_q <= in_i.data.raw_right[EFF-1:0];
      raw_l_q <= in_i.data.raw_left[EFF-1:0];
      start_q <= in_i.data.start_pressed;
      stop_q  <= in_i.data.stop_pressed;
    end
  end

  // filtered distances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_f_q <= oadc_pkg::FRONT_DIST_RESET;
      dist_r_q <= oadc_pkg::SIDE_DIST_RESET;
      dist_l_q <= oadc_pkg::SIDE_DIST_RESET;
    end else if (state_q == oadc_pkg::SEQ_WAIT && div_done) begin
      case (ch_q)
        oadc_pkg::CH_FRONT: dist_f_q <= avg;
        oadc_pkg::CH_RIGHT: dist_r_q <= avg[6:0];
        default:            dist_l_q <= avg[6:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= oadc_pkg::CFG_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        oadc_pkg::REG_FRONT_GAP:   cfg_q.front_gap        <= cfg_i.data.value[7:0];
        oadc_pkg::REG_SIDE_GAP:    cfg_q.side_gap         <= cfg_i.data.value[7:0];
        oadc_pkg::REG_TURN_RESET:  cfg_q.turn_reset_ticks <= cfg_i.data.value;
        oadc_pkg::REG_TURN_LIMIT:  cfg_q.turn_limit       <= cfg_i.data.value[2:0];
        oadc_pkg::REG_CRUISE_DUTY: cfg_q.cruise_duty      <= cfg_i.data.value[7:0];
        oadc_pkg::REG_TURN_SPEED:  cfg_q.turn_speed       <= cfg_i.data.value[7:0];
        default: ;
      endcase
    end
  end

  oadc_drive u_drive (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (res_load),
    .start_i      (start_q),
    .stop_i       (stop_q),
    .dist_front_i (dist_f_q),
    .dist_right_i (dist_r_q),
    .dist_left_i  (dist_l_q),
    .cfg_i        (cfg_q),
    .res_o        (drv_res)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_data_q.drive_mode  <= drv_res.drive_mode;
      out_data_q.pin_pattern <= drv_res.pin_pattern;
      out_data_q.pwm_duty    <= drv_res.pwm_duty;
      out_data_q.run_mode    <= drv_res.run_mode;
      out_data_q.dist_front  <= dist_f_q;
      out_data_q.dist_right  <= dist_r_q;
      out_data_q.dist_left   <= dist_l_q;
      out_data_q.right_turns <= drv_res.right_turns;
      out_data_q.left_turns  <= drv_res.left_turns;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  `OADC_ASSERT_NEXT(a_accept_busy, in_i.valid && in_i.ready, !in_i.ready)
  `OADC_ASSERT(a_done_in_wait, div_done |-> (state_q == oadc_pkg::SEQ_WAIT))
  `OADC_ASSERT(a_load_slot_free, res_load |-> (!out_valid_q || out_o.ready))
  `OADC_ASSERT(a_start_idle_div, div_start |-> !div_done)

endmodule

// ===== test/drive_tick_checker.sv =====
`timescale 1ns / 1ps

module drive_tick_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  oadc_chan_if  in_mon,
  oadc_chan_if  out_mon,
  oadc_chan_if  cfg_mon,
  output int    errors_o,
  output int    pending_o
);

  oadc_pkg::cfg_t      cfg;
  oadc_pkg::run_mode_e mode;
  int                  d_front;
  int                  d_right;
  int                  d_left;
  bit                  go_left;
  int                  right_cnt;
  int                  left_cnt;
  int                  idle_ticks;
  int                  fail_count;
  oadc_pkg::out_word_t expected_ticks[$];

  assign errors_o = fail_count;

  // raw sample to cm, with the out-of-range codes one past each bound
  function automatic int range_cm(int raw, int scale, int offs, int k, int hi, int lo);
    int v;
    v = scale / (16 * raw + offs) - k;
    if (v > hi) begin
      v = hi + 1;
    end else if (v < lo) begin
      v = lo - 1;
    end
    return v;
  endfunction

  function automatic oadc_pkg::out_word_t predict_tick(oadc_pkg::in_word_t w);
    int                  vf;
    int                  vr;
    int                  vl;
    bit                  blocked;
    oadc_pkg::out_word_t r;
    if (idle_ticks < 65535) idle_ticks++;
    if (w.start_pressed && mode == oadc_pkg::RUN_STOP) mode = oadc_pkg::RUN_FWD;
    if (w.stop_pressed) mode = oadc_pkg::RUN_STOP;
    vf = range_cm(int'(w.raw_front), 302077, 723, 15, 150, 20);
    vr = range_cm(int'(w.raw_right), 362057, 971, 30, 80, 10);
    vl = range_cm(int'(w.raw_left), 280009, 971, 30, 80, 10);
    d_front = (vf + d_front) / 2;
    d_right = (vr + d_right) / 2;
    d_left  = (vl + d_left) / 2;
    blocked = d_front < int'(cfg.front_gap) || d_right < int'(cfg.side_gap) ||
              d_left < int'(cfg.side_gap);
    r = '0;
    case (mode)
      oadc_pkg::RUN_FWD: begin
        // the detecting tick still drives forward
        r.drive_mode  = oadc_pkg::DRV_FWD;
        r.pin_pattern = oadc_pkg::PINS_FWD;
        r.pwm_duty    = cfg.cruise_duty;
        if (idle_ticks >= int'(cfg.turn_reset_ticks)) begin
          right_cnt = 0;
          left_cnt  = 0;
        end
        if (blocked) begin
          go_left = d_right > d_left;
          // anti-loop: right limit is checked first
          if (right_cnt >= int'(cfg.turn_limit)) begin
            go_left   = 1'b1;
            right_cnt = 0;
          end else if (left_cnt >= int'(cfg.turn_limit)) begin
            go_left  = 1'b0;
            left_cnt = 0;
          end
          if (go_left) begin
            if (left_cnt < 7) left_cnt++;
          end else begin
            if (right_cnt < 7) right_cnt++;
          end
          idle_ticks = 0;
          mode = oadc_pkg::RUN_TURN;
        end
      end
      oadc_pkg::RUN_TURN: begin
        r.pwm_duty = cfg.turn_speed;
        if (go_left) begin
          r.drive_mode  = oadc_pkg::DRV_LEFT;
          r.pin_pattern = oadc_pkg::PINS_LEFT;
        end else begin
          r.drive_mode  = oadc_pkg::DRV_RIGHT;
          r.pin_pattern = oadc_pkg::PINS_RIGHT;
        end
        if (!blocked) mode = oadc_pkg::RUN_FWD;
      end
      default: begin
        mode          = oadc_pkg::RUN_STOP;
        r.drive_mode  = oadc_pkg::DRV_STOP;
        r.pin_pattern = oadc_pkg::PINS_STOP;
        r.pwm_duty    = cfg.cruise_duty;
      end
    endcase
    r.run_mode    = mode;
    r.dist_front  = 8'(d_front);
    r.dist_right  = 7'(d_right);
    r.dist_left   = 7'(d_left);
    r.right_turns = 3'(right_cnt);
    r.left_turns  = 3'(left_cnt);
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    oadc_pkg::cfg_word_t cw;
    oadc_pkg::in_word_t  iw;
    oadc_pkg::out_word_t ow;
    oadc_pkg::out_word_t ew;
    if (!rst_ni) begin
      cfg        = oadc_pkg::CFG_RESET;
      mode       = oadc_pkg::RUN_STOP;
      d_front    = int'(oadc_pkg::FRONT_DIST_RESET);
      d_right    = int'(oadc_pkg::SIDE_DIST_RESET);
      d_left     = int'(oadc_pkg::SIDE_DIST_RESET);
      go_left    = 1'b0;
      right_cnt  = 0;
      left_cnt   = 0;
      idle_ticks = 0;
      fail_count = 0;
      expected_ticks.delete();
      pending_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        cw = cfg_mon.data;
        case (cw.index)
          oadc_pkg::REG_FRONT_GAP:   cfg.front_gap        = cw.value[7:0];
          oadc_pkg::REG_SIDE_GAP:    cfg.side_gap         = cw.value[7:0];
          oadc_pkg::REG_TURN_RESET:  cfg.turn_reset_ticks = cw.value;
          oadc_pkg::REG_TURN_LIMIT:  cfg.turn_limit       = cw.value[2:0];
          oadc_pkg::REG_CRUISE_DUTY: cfg.cruise_duty      = cw.value[7:0];
          oadc_pkg::REG_TURN_SPEED:  cfg.turn_speed       = cw.value[7:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        ow = out_mon.data;
        if (expected_ticks.size() == 0) begin
          $error("result word with no expected word pending");
          fail_count++;
        end else begin
          ew = expected_ticks.pop_front();
          check_field("drive_mode", 16'(ew.drive_mode), 16'(ow.drive_mode));
          check_field("pin_pattern", 16'(ew.pin_pattern), 16'(ow.pin_pattern));
          check_field("pwm_duty", 16'(ew.pwm_duty), 16'(ow.pwm_duty));
          check_field("run_mode", 16'(ew.run_mode), 16'(ow.run_mode));
          check_field("dist_front", 16'(ew.dist_front), 16'(ow.dist_front));
          check_field("dist_right", 16'(ew.dist_right), 16'(ow.dist_right));
          check_field("dist_left", 16'(ew.dist_left), 16'(ow.dist_left));
          check_field("right_turns", 16'(ew.right_turns), 16'(ow.right_turns));
          check_field("left_turns", 16'(ew.left_turns), 16'(ow.left_turns));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        iw = in_mon.data;
        expected_ticks.push_back(predict_tick(iw));
      end
      pending_o <= expected_ticks.size();
    end
  end

endmodule

// ===== test/obstacle_avoid_drive_controller_test.sv =====
`timescale 1ns / 1ps

module obstacle_avoid_drive_controller_test;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   cycles = 0;
  bit   calm = 1'b0;
  int   hold_requests = 0;
  int   holds_done = 0;

  oadc_chan_if #(.T(oadc_pkg::in_word_t))  in_ch ();
  oadc_chan_if #(.T(oadc_pkg::out_word_t)) out_ch ();
  oadc_chan_if #(.T(oadc_pkg::cfg_word_t)) cfg_ch ();

  obstacle_avoid_drive_controller i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  drive_tick_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_mon   (cfg_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (holds_done != hold_requests) begin
        holds_done++;
        stall = 250;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  task automatic send_tick(input oadc_pkg::in_word_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic dir(input int f, input int r, input int l, input bit go, input bit halt);
    oadc_pkg::in_word_t w;
    w.raw_front     = 10'(f);
    w.raw_right     = 10'(r);
    w.raw_left      = 10'(l);
    w.start_pressed = go;
    w.stop_pressed  = halt;
    send_tick(w);
  endtask

  // all six registers back to back, valid held high across them
  task automatic write_cfg(input oadc_pkg::cfg_t c);
    oadc_pkg::cfg_word_t words[6];
    words[0] = '{index: oadc_pkg::REG_FRONT_GAP,   value: 16'(c.front_gap)};
    words[1] = '{index: oadc_pkg::REG_SIDE_GAP,    value: 16'(c.side_gap)};
    words[2] = '{index: oadc_pkg::REG_TURN_RESET,  value: c.turn_reset_ticks};
    words[3] = '{index: oadc_pkg::REG_TURN_LIMIT,  value: 16'(c.turn_limit)};
    words[4] = '{index: oadc_pkg::REG_CRUISE_DUTY, value: 16'(c.cruise_duty)};
    words[5] = '{index: oadc_pkg::REG_TURN_SPEED,  value: 16'(c.turn_speed)};
    for (int i = 0; i < 6; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= words[i];
      do @(posedge clk_i); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // mostly clear road so the vehicle gets to drive; near samples use the full range
  function automatic logic [9:0] raw_sample();
    if ($urandom_range(0, 3) != 0) return 10'($urandom_range(0, 180));
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic oadc_pkg::in_word_t random_tick();
    oadc_pkg::in_word_t w;
    w.raw_front     = raw_sample();
    w.raw_right     = raw_sample();
    w.raw_left      = raw_sample();
    w.start_pressed = ($urandom_range(0, 7) == 0);
    w.stop_pressed  = ($urandom_range(0, 24) == 0);
    return w;
  endfunction

  function automatic oadc_pkg::cfg_t random_cfg();
    oadc_pkg::cfg_t c;
    c.front_gap = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(20, 160))
                                               : 8'($urandom_range(0, 255));
    c.side_gap  = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(9, 85))
                                               : 8'($urandom_range(0, 255));
    c.turn_reset_ticks = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(1, 200))
                                                      : 16'($urandom);
    c.turn_limit  = 3'($urandom_range(0, 7));
    c.cruise_duty = 8'($urandom_range(0, 255));
    c.turn_speed  = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 59) == 0) wait_drained();
      send_tick(random_tick());
    end
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    rst_ni       <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(oadc_pkg::CFG_RESET);
    dir(0, 0, 0, 0, 0);
    dir(1023, 1023, 1023, 0, 0);
    dir(0, 0, 0, 1, 0);
    dir(0, 0, 0, 0, 0);
    // front obstacle, then clear road
    repeat (3) dir(1023, 0, 0, 0, 0);
    dir(1023, 0, 0, 0, 0);
    repeat (2) dir(0, 0, 0, 0, 0);
    // left side near: spin left
    repeat (3) dir(0, 0, 1023, 0, 0);
    repeat (2) dir(0, 0, 0, 0, 0);
    // right side near: spin right
    repeat (3) dir(0, 1023, 0, 0, 0);
    repeat (2) dir(0, 0, 0, 0, 0);
    dir(0, 0, 0, 1, 1);
    dir(0, 0, 0, 0, 1);
    dir(512, 512, 512, 1, 0);
    dir(1023, 1023, 1023, 0, 0);
    wait_drained();

    // always blocked, fastest forcing
    write_cfg('{front_gap: 8'd255, side_gap: 8'd255, turn_reset_ticks: 16'd65535,
                turn_limit: 3'd1, cruise_duty: 8'd0, turn_speed: 8'd255});
    run_random(40);
    wait_drained();
    // never blocked
    write_cfg('{front_gap: 8'd0, side_gap: 8'd0, turn_reset_ticks: 16'd1,
                turn_limit: 3'd6, cruise_duty: 8'd255, turn_speed: 8'd0});
    run_random(40);
    wait_drained();
    // counters cleared every forward tick; zero limit always forces left
    write_cfg('{front_gap: 8'd60, side_gap: 8'd30, turn_reset_ticks: 16'd0,
                turn_limit: 3'd0, cruise_duty: 8'd17, turn_speed: 8'd200});
    run_random(40);
    wait_drained();
    write_cfg('{front_gap: 8'd0, side_gap: 8'd0, turn_reset_ticks: 16'd65535,
                turn_limit: 3'd0, cruise_duty: 8'd90, turn_speed: 8'd33});
    run_random(10);
    wait_drained();
    // counters can run up to saturation
    write_cfg('{front_gap: 8'd120, side_gap: 8'd60, turn_reset_ticks: 16'd65535,
                turn_limit: 3'd7, cruise_duty: 8'd100, turn_speed: 8'd50});
    run_random(40);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      write_cfg(random_cfg());
      calm = ($urandom_range(0, 3) == 0);
      if (p == 2) begin
        calm = 1'b0;
        hold_requests++;
      end
      run_random(60);
      wait_drained();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
